// ===== hw/rtl/baro_temp_compensation_core_assert.svh =====
// Assertion macros for the barometric compensation core.
// Included by files that check their own logic; no other dependencies.
`ifndef BARO_TEMP_COMPENSATION_CORE_ASSERT_SVH
`define BARO_TEMP_COMPENSATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btc assertion failed");
`define BTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btc assertion failed");
`else
`define BTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BTC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/btc_pkg.sv =====
// Shared constants and helpers for the barometric compensation core.
// No dependencies; used by the divider and the top level.
`timescale 1ns / 1ps

package btc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RAW_W  = 20;
  localparam int unsigned CNT_W  = $clog2(DATA_W + 1);

  localparam logic [DATA_W-1:0] OFFS_FINE   = 32'd64000;
  localparam logic [DATA_W-1:0] RAW_FULL    = 32'd1048576;
  localparam logic [DATA_W-1:0] SCALE_PRESS = 32'd3125;
  localparam logic [DATA_W-1:0] HALF_RANGE  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] P1_OFFS     = 32'd32768;
  localparam logic [DATA_W-1:0] TEMP_ROUND  = 32'd128;

  // Arithmetic right shift of a 32-bit two's complement word.
  function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] x,
                                            input int unsigned n);
    return DATA_W'($signed(x) >>> n);
  endfunction

  function automatic logic [DATA_W-1:0] sx16(input logic [15:0] x);
    return {{(DATA_W-16){x[15]}}, x};
  endfunction

endpackage

// ===== hw/rtl/btc_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Uses btc_pkg for the data width.
`timescale 1ns / 1ps

module btc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [btc_pkg::DATA_W-1:0] num,
  input  logic [btc_pkg::DATA_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [btc_pkg::DATA_W-1:0] quot
);

  logic [btc_pkg::DATA_W-1:0] quo_r, den_r;
  logic [btc_pkg::DATA_W-1:0] rem_r;
  logic [btc_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r, done_r;
  logic [btc_pkg::DATA_W:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_r, quo_r[btc_pkg::DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= btc_pkg::CNT_W'(btc_pkg::DATA_W);
        quo_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        // The shifted remainder is below twice the divisor, so one subtract suffices.
        if (!rem_sub[btc_pkg::DATA_W]) begin
          rem_r <= rem_sub[btc_pkg::DATA_W-1:0];
          quo_r <= {quo_r[btc_pkg::DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[btc_pkg::DATA_W-1:0];
          quo_r <= {quo_r[btc_pkg::DATA_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == btc_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hw/rtl/baro_temp_compensation_core.sv =====
// Top level of the barometric compensation core: register port, sequencer
// and shared multiplier. Depends on btc_pkg, btc_div and the assertion header.
// A new word is accepted only in idle; the shared multiplier and divider set the
// work per word: every multiply step has a multiply phase and a store phase,
// temperature is four steps, pressure is ten steps plus a serial divide, and with
// neither selected the word goes straight to loading the result register, which
// always comes before the return to idle. A zero divisor ends pressure before the
// divide, and a stalled result holds the block busy.
`timescale 1ns / 1ps

`include "baro_temp_compensation_core_assert.svh"

module baro_temp_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_raw_pressure,
  input  logic [19:0] in_raw_temperature,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_temperature,
  output logic signed [31:0] out_pressure,
  output logic        out_press_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    ST_T_A  = 4'd0,
    ST_T_D  = 4'd1,
    ST_T_B  = 4'd2,
    ST_T_O  = 4'd3,
    ST_P_QQ = 4'd4,
    ST_P_6  = 4'd5,
    ST_P_5  = 4'd6,
    ST_P_3  = 4'd7,
    ST_P_2  = 4'd8,
    ST_P_1  = 4'd9,
    ST_P_N  = 4'd10,
    ST_P_SQ = 4'd11,
    ST_P_9  = 4'd12,
    ST_P_8  = 4'd13
  } step_t;

  typedef enum logic [2:0] {
    REG_TEMP  = 3'd0,
    REG_PLOW  = 3'd1,
    REG_PHIGH = 3'd2,
    REG_P9    = 3'd3,
    REG_SEL   = 3'd4
  } reg_idx_t;

  localparam int unsigned W = btc_pkg::DATA_W;

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_coeffs_low_r, press_coeffs_high_r;
  logic [15:0] press_coeff_nine_r;
  logic [1:0]  measure_select_r;

  state_t state_r;
  step_t  step_r;
  logic   phase_r;
  logic [19:0]  rawp_r, rawt_r;
  logic [W-1:0] prod_r, fine_r, temp_r, press_r;
  logic [W-1:0] x_r, acc_r, qq_r, v1_r, v2_r;
  logic         err_r, big_r;
  logic         out_valid_r, out_err_r;
  logic [W-1:0] out_temp_r, out_press_r;

  logic [W-1:0] mul_a, mul_b, v1c, t1, p1, post_v1;
  logic         in_acc, out_acc, cfg_wr, out_load;
  logic         div_start, div_busy, div_done;
  logic [W-1:0] div_num, div_quot;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    unique case (reg_idx_t'(paddr[5:3]))
      REG_TEMP:  prdata = {16'b0, temp_coeffs_r};
      REG_PLOW:  prdata = press_coeffs_low_r;
      REG_PHIGH: prdata = press_coeffs_high_r;
      REG_P9:    prdata = {48'b0, press_coeff_nine_r};
      REG_SEL:   prdata = {62'b0, measure_select_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r       <= '0;
      press_coeffs_low_r  <= '0;
      press_coeffs_high_r <= '0;
      press_coeff_nine_r  <= '0;
      measure_select_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[5:3]))
        REG_TEMP:  temp_coeffs_r       <= pwdata[47:0];
        REG_PLOW:  press_coeffs_low_r  <= pwdata;
        REG_PHIGH: press_coeffs_high_r <= pwdata;
        REG_P9:    press_coeff_nine_r  <= pwdata[15:0];
        REG_SEL:   measure_select_r    <= pwdata[1:0];
        default:   ;
      endcase
    end
  end

  assign t1  = {16'b0, temp_coeffs_r[15:0]};
  assign p1  = {16'b0, press_coeffs_low_r[15:0]};
  assign v1c = btc_pkg::asr(fine_r, 1) - btc_pkg::OFFS_FINE;

  // Operand selection for the one shared multiplier.
  always_comb begin
    unique case (step_r)
      ST_T_A: begin
        mul_a = W'(rawt_r >> 3) - (t1 << 1);
        mul_b = btc_pkg::sx16(temp_coeffs_r[31:16]);
      end
      ST_T_D: begin
        mul_a = W'(rawt_r >> 4) - t1;
        mul_b = W'(rawt_r >> 4) - t1;
      end
      ST_T_B: begin
        mul_a = acc_r;
        mul_b = btc_pkg::sx16(temp_coeffs_r[47:32]);
      end
      ST_T_O: begin
        mul_a = fine_r;
        mul_b = 32'd5;
      end
      ST_P_QQ: begin
        mul_a = btc_pkg::asr(v1c, 2);
        mul_b = btc_pkg::asr(v1c, 2);
      end
      ST_P_6: begin
        mul_a = btc_pkg::asr(qq_r, 11);
        mul_b = btc_pkg::sx16(press_coeffs_high_r[31:16]);
      end
      ST_P_5: begin
        mul_a = v1_r;
        mul_b = btc_pkg::sx16(press_coeffs_high_r[15:0]);
      end
      ST_P_3: begin
        mul_a = btc_pkg::asr(qq_r, 13);
        mul_b = btc_pkg::sx16(press_coeffs_low_r[47:32]);
      end
      ST_P_2: begin
        mul_a = v1_r;
        mul_b = btc_pkg::sx16(press_coeffs_low_r[31:16]);
      end
      ST_P_1: begin
        mul_a = btc_pkg::P1_OFFS + v1_r;
        mul_b = p1;
      end
      ST_P_N: begin
        mul_a = (btc_pkg::RAW_FULL - W'(rawp_r)) - btc_pkg::asr(v2_r, 12);
        mul_b = btc_pkg::SCALE_PRESS;
      end
      ST_P_SQ: begin
        mul_a = press_r >> 3;
        mul_b = press_r >> 3;
      end
      ST_P_9: begin
        mul_a = x_r >> 13;
        mul_b = btc_pkg::sx16(press_coeff_nine_r);
      end
      ST_P_8: begin
        mul_a = press_r >> 2;
        mul_b = btc_pkg::sx16(press_coeffs_high_r[63:48]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign post_v1   = btc_pkg::asr(prod_r, 15);
  assign div_start = (state_r == S_CALC) && phase_r && (step_r == ST_P_N);
  assign div_num   = prod_r[W-1] ? prod_r : (prod_r << 1);

  btc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (v1_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_T_A;
      phase_r     <= 1'b0;
      fine_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            rawp_r  <= in_raw_pressure;
            rawt_r  <= in_raw_temperature;
            temp_r  <= '0;
            press_r <= '0;
            err_r   <= 1'b0;
            phase_r <= 1'b0;
            if (measure_select_r[1]) begin
              step_r  <= ST_T_A;
              state_r <= S_CALC;
            end else if (measure_select_r[0]) begin
              step_r  <= ST_P_QQ;
              state_r <= S_CALC;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_CALC: begin
          phase_r <= !phase_r;
          if (!phase_r) begin
            prod_r <= mul_a * mul_b;
          end else begin
            step_r <= step_t'(step_r + 1'b1);
            unique case (step_r)
              ST_T_A: x_r <= btc_pkg::asr(prod_r, 11);
              ST_T_D: acc_r <= btc_pkg::asr(prod_r, 12);
              ST_T_B: fine_r <= x_r + btc_pkg::asr(prod_r, 14);
              ST_T_O: begin
                temp_r <= btc_pkg::asr(prod_r + btc_pkg::TEMP_ROUND, 8);
                if (!measure_select_r[0]) begin
                  state_r <= S_DONE;
                end
              end
              ST_P_QQ: begin
                qq_r <= prod_r;
                v1_r <= v1c;
              end
              ST_P_6: v2_r <= prod_r;
              ST_P_5: v2_r <= btc_pkg::asr(v2_r + (prod_r << 1), 2)
                              + {press_coeffs_low_r[63:48], 16'b0};
              ST_P_3: x_r <= prod_r;
              ST_P_2: v1_r <= btc_pkg::asr(btc_pkg::asr(x_r, 3)
                                           + btc_pkg::asr(prod_r, 1), 18);
              ST_P_1: begin
                v1_r <= post_v1;
                // A zero divisor ends the word with the error flag set.
                if (post_v1 == '0) begin
                  err_r   <= 1'b1;
                  state_r <= S_DONE;
                end
              end
              ST_P_N: begin
                big_r   <= !(prod_r < btc_pkg::HALF_RANGE);
                state_r <= S_DIV;
              end
              ST_P_SQ: x_r <= prod_r;
              ST_P_9: acc_r <= btc_pkg::asr(prod_r, 12);
              ST_P_8: begin
                press_r <= press_r + btc_pkg::asr(acc_r + btc_pkg::asr(prod_r, 13)
                           + btc_pkg::sx16(press_coeffs_high_r[47:32]), 4);
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            press_r <= big_r ? (div_quot << 1) : div_quot;
            step_r  <= ST_P_SQ;
            phase_r <= 1'b0;
            state_r <= S_CALC;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_temp_r  <= temp_r;
            out_press_r <= press_r;
            out_err_r   <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_pressure    = out_press_r;
  assign out_press_error = out_err_r;

  `BTC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall)
  `BTC_ASSERT_IMP(a_div_only_in_div, clk, rst_n, div_busy, state_r == S_DIV)
  `BTC_ASSERT_IMP(a_err_zero_press, clk, rst_n, out_valid_r && out_err_r,
                  out_press_r == '0)

endmodule
